// ----- hdl/aes_pkg.sv -----
// AES package: constants, types, S-box tables and round functions.
// Used by aes_block_cipher. No dependencies.
package aes_pkg;

  localparam int unsigned NumStages = 15;
  localparam int unsigned KeyWin    = 8;

  localparam logic [2:0] RegKey0    = 3'd0;
  localparam logic [2:0] RegKey1    = 3'd1;
  localparam logic [2:0] RegKey2    = 3'd2;
  localparam logic [2:0] RegKey3    = 3'd3;
  localparam logic [2:0] RegKeySize = 3'd4;

  typedef enum logic [1:0] {
    KeySize128 = 2'd0,
    KeySize192 = 2'd1,
    KeySize256 = 2'd2
  } key_size_e;

  typedef logic [7:0] sbox_tab_t [256];

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    logic [7:0] aa;
    r  = 8'h00;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ aa;
      aa = xt(aa);
    end
    return r;
  endfunction

  function automatic sbox_tab_t gen_sbox();
    sbox_tab_t  t;
    logic [7:0] p;
    logic [7:0] r;
    for (int x = 0; x < 256; x++) begin
      p = 8'(x);
      r = 8'h01;
      for (int i = 0; i < 7; i++) begin
        p = gmul(p, p);
        r = gmul(r, p);
      end
      t[x] = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^
             {r[3:0], r[7:4]} ^ 8'h63;
    end
    return t;
  endfunction

  function automatic sbox_tab_t gen_inv_sbox();
    sbox_tab_t s;
    sbox_tab_t t;
    s = gen_sbox();
    for (int x = 0; x < 256; x++) t[s[x]] = 8'(x);
    return t;
  endfunction

  localparam sbox_tab_t SBOX     = gen_sbox();
  localparam sbox_tab_t INV_SBOX = gen_inv_sbox();

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_word(logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_word(logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4], m11 [4], m13 [4], m14 [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]   = w[31-8*i -: 8];
      x2     = xt(a[i]);
      x4     = xt(x2);
      x8     = xt(x4);
      m9[i]  = x8 ^ a[i];
      m11[i] = x8 ^ x2 ^ a[i];
      m13[i] = x8 ^ x4 ^ a[i];
      m14[i] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] st);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = SBOX[st[127-8*(4*((c+r)&3)+r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(logic [127:0] st);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*((c+r)&3)+r) -: 8] = INV_SBOX[st[127-8*(4*c+r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] enc_round(logic [127:0] st);
    logic [127:0] t;
    t = sub_shift(st);
    for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_word(t[127-32*c -: 32]);
    return t;
  endfunction

  function automatic logic [127:0] dec_round(logic [127:0] st);
    logic [127:0] t;
    t = inv_sub_shift(st);
    for (int c = 0; c < 4; c++) t[127-32*c -: 32] = inv_mix_word(t[127-32*c -: 32]);
    return t;
  endfunction

endpackage

// ----- hdl/aes_block_cipher.sv -----
// AES-128/192/256 ECB cipher, one round per pipeline stage, with key schedule sequencer.
// Depends on aes_pkg.
// Each word passes through all 15 round pipeline stages, for every key size.
// Throughput: one word per cycle, unless held off by out_ready_i low or key expansion.
// A register write starts key expansion of 4*(Nr+1) words (44, 52 or 60), input held off.
// Reset clears valid bits, key registers and key size; round keys are undefined until
// the first register write.
module aes_block_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         func_i,
  input  logic [63:0]  block_hi_i,
  input  logic [63:0]  block_lo_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  result_hi_o,
  output logic [63:0]  result_lo_o
);
  import aes_pkg::*;

  logic [63:0] key_q [4];
  key_size_e   ks_q;

  logic        busy_q;
  logic [5:0]  idx_q;
  logic [2:0]  mod_q;
  logic [7:0]  rcon_q;
  logic [31:0] win_q [KeyWin];

  logic [127:0] ek_q [NumStages];
  logic [127:0] dk_q [NumStages];

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] f_q;
  logic [127:0]         st_q  [NumStages];
  logic [127:0]         nxt   [NumStages];
  logic [NumStages-1:0] rdy;

  logic        cfg_wr;
  logic [2:0]  nk_m1;
  logic [3:0]  nr;
  logic [3:0]  skip;
  logic [31:0] kword, ktmp, kraw;
  logic [3:0]  rnd;
  logic [1:0]  col;
  logic [3:0]  ek_stage, dk_stage;
  logic [31:0] dword;
  logic [6:0]  col_off;
  logic        first;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[5:3])
      RegKey0:    prdata = key_q[0];
      RegKey1:    prdata = key_q[1];
      RegKey2:    prdata = key_q[2];
      RegKey3:    prdata = key_q[3];
      RegKeySize: prdata = {62'd0, ks_q};
      default:    prdata = 64'd0;
    endcase
  end

  always_comb begin
    case (ks_q)
      KeySize128: begin nk_m1 = 3'd3; nr = 4'd10; skip = 4'd4; end
      KeySize192: begin nk_m1 = 3'd5; nr = 4'd12; skip = 4'd2; end
      default:    begin nk_m1 = 3'd7; nr = 4'd14; skip = 4'd0; end
    endcase
  end

  // key schedule word generator
  always_comb begin
    first = idx_q[5:0] <= {3'd0, nk_m1};
    kraw  = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
    ktmp  = win_q[0];
    if (mod_q == 3'd0) begin
      ktmp = sub_word({ktmp[23:0], ktmp[31:24]}) ^ {rcon_q, 24'd0};
    end else if (nk_m1 == 3'd7 && mod_q == 3'd4) begin
      ktmp = sub_word(ktmp);
    end
    kword    = first ? kraw : (win_q[nk_m1] ^ ktmp);
    rnd      = idx_q[5:2];
    col      = idx_q[1:0];
    ek_stage = (rnd == 4'd0) ? 4'd0 : rnd + skip;
    dk_stage = (rnd == nr) ? 4'd0 : 4'd14 - rnd;
    dword    = (rnd == 4'd0 || rnd == nr) ? kword : inv_mix_word(kword);
    col_off  = {2'd3 - col, 5'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
      ks_q   <= KeySize128;
      busy_q <= 1'b0;
      idx_q  <= 6'd0;
      mod_q  <= 3'd0;
      rcon_q <= 8'h01;
    end else if (cfg_wr && paddr[5:3] <= RegKeySize) begin
      if (paddr[5:3] == RegKeySize) begin
        ks_q <= (pwdata[1:0] == 2'd3) ? KeySize256 : key_size_e'(pwdata[1:0]);
      end else begin
        key_q[paddr[4:3]] <= pwdata;
      end
      busy_q <= 1'b1;
      idx_q  <= 6'd0;
      mod_q  <= 3'd0;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      idx_q <= idx_q + 6'd1;
      mod_q <= (mod_q == nk_m1) ? 3'd0 : mod_q + 3'd1;
      if (!first && mod_q == 3'd0) rcon_q <= xt(rcon_q);
      if (idx_q == {nr, 2'b11}) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      win_q[0] <= kword;
      for (int i = 1; i < KeyWin; i++) win_q[i] <= win_q[i-1];
      ek_q[ek_stage][col_off +: 32] <= kword;
      dk_q[dk_stage][col_off +: 32] <= dword;
    end
  end

  // round pipeline
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) rdy[s] = !v_q[s] || rdy[s+1];
  end

  assign in_ready_o = rdy[0] && !busy_q;

  always_comb begin
    nxt[0] = {block_hi_i, block_lo_i} ^ (func_i ? dk_q[0] : ek_q[0]);
    for (int s = 1; s < NumStages - 1; s++) begin
      if (4'(s) <= skip) nxt[s] = st_q[s-1];
      else if (f_q[s-1]) nxt[s] = dec_round(st_q[s-1]) ^ dk_q[s];
      else nxt[s] = enc_round(st_q[s-1]) ^ ek_q[s];
    end
    nxt[NumStages-1] = f_q[NumStages-2] ?
                       (inv_sub_shift(st_q[NumStages-2]) ^ dk_q[NumStages-1]) :
                       (sub_shift(st_q[NumStages-2]) ^ ek_q[NumStages-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i && in_ready_o;
      for (int s = 1; s < NumStages; s++) if (rdy[s]) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      st_q[0] <= nxt[0];
      f_q[0]  <= func_i;
    end
    for (int s = 1; s < NumStages; s++) begin
      if (rdy[s]) begin
        st_q[s] <= nxt[s];
        f_q[s]  <= f_q[s-1];
      end
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign result_hi_o = st_q[NumStages-1][127:64];
  assign result_lo_o = st_q[NumStages-1][63:0];

endmodule

// ----- test/aes_block_cipher_chk.sv -----
// Checker for aes_block_cipher: follows the APB register writes and both
// word channels, computes each AES block result itself and compares. Uses aes_pkg types.
`timescale 1ns / 100ps
module aes_block_cipher_chk import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        func_i,
  input  logic [63:0] block_hi_i,
  input  logic [63:0] block_lo_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [63:0] result_hi_o,
  input  logic [63:0] result_lo_o,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  logic [63:0]  key_q [4];
  key_size_e    ksize_q;
  logic [31:0]  ekeys [60];
  logic [31:0]  dkeys [60];
  logic [127:0] cipher_q [$];

  function automatic logic [7:0] mul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = mul2(a);
    end
    return acc;
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] p, v;
    p = x;
    v = 8'h01;
    for (int i = 0; i < 7; i++) begin
      p = fmul(p, p);
      v = fmul(v, p);
    end
    return v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
           ^ 8'h63;
  endfunction

  logic [7:0] fsub [256];
  logic [7:0] rsub [256];
  initial for (int x = 0; x < 256; x++) begin
    fsub[x] = fwd_sub(8'(x));
    rsub[fsub[x]] = 8'(x);
  end

  function automatic logic [31:0] col_mix(logic [31:0] w, bit inv);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = w;
    if (inv)
      return {fmul(a0, 14) ^ fmul(a1, 11) ^ fmul(a2, 13) ^ fmul(a3, 9),
              fmul(a0, 9) ^ fmul(a1, 14) ^ fmul(a2, 11) ^ fmul(a3, 13),
              fmul(a0, 13) ^ fmul(a1, 9) ^ fmul(a2, 14) ^ fmul(a3, 11),
              fmul(a0, 11) ^ fmul(a1, 13) ^ fmul(a2, 9) ^ fmul(a3, 14)};
    return {fmul(a0, 2) ^ fmul(a1, 3) ^ a2 ^ a3, a0 ^ fmul(a1, 2) ^ fmul(a2, 3) ^ a3,
            a0 ^ a1 ^ fmul(a2, 2) ^ fmul(a3, 3), fmul(a0, 3) ^ a1 ^ a2 ^ fmul(a3, 2)};
  endfunction

  function automatic int nk_words();
    return ksize_q == KeySize128 ? 4 : (ksize_q == KeySize192 ? 6 : 8);
  endfunction

  function automatic void expand_schedule();
    int nk, nr;
    logic [31:0] t;
    logic [7:0] rc;
    nk = nk_words();
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < 60; i++) begin
      ekeys[i] = 0;
      dkeys[i] = 0;
    end
    for (int i = 0; i < nk; i++)
      ekeys[i] = i[0] ? key_q[i / 2][31:0] : key_q[i / 2][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = ekeys[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fsub[t[31:24]], fsub[t[23:16]], fsub[t[15:8]], fsub[t[7:0]]} ^ {rc, 24'h0};
        rc = mul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {fsub[t[31:24]], fsub[t[23:16]], fsub[t[15:8]], fsub[t[7:0]]};
      end
      ekeys[i] = ekeys[i - nk] ^ t;
    end
    for (int i = 0; i < 4 * (nr + 1); i++)
      dkeys[i] = (i < 4 || i >= 4 * nr) ? ekeys[i] : col_mix(ekeys[i], 1'b1);
  endfunction

  function automatic logic [127:0] round_key(bit dec, int rnd);
    return dec ? {dkeys[4*rnd], dkeys[4*rnd+1], dkeys[4*rnd+2], dkeys[4*rnd+3]}
               : {ekeys[4*rnd], ekeys[4*rnd+1], ekeys[4*rnd+2], ekeys[4*rnd+3]};
  endfunction

  function automatic logic [127:0] byte_round(logic [127:0] s, bit inv, bit do_mix);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[127-8*(4*((c+r)&3)+r) -: 8] = rsub[s[127-8*(4*c+r) -: 8]];
        else t[127-8*(4*c+r) -: 8] = fsub[s[127-8*(4*((c+r)&3)+r) -: 8]];
    if (do_mix)
      for (int c = 0; c < 4; c++) t[127-32*c -: 32] = col_mix(t[127-32*c -: 32], inv);
    return t;
  endfunction

  function automatic logic [127:0] aes_block(bit dec, logic [127:0] s);
    int nr;
    nr = nk_words() + 6;
    if (!dec) begin
      s ^= round_key(0, 0);
      for (int r = 1; r < nr; r++) s = byte_round(s, 0, 1) ^ round_key(0, r);
      s = byte_round(s, 0, 0) ^ round_key(0, nr);
    end else begin
      s ^= round_key(0, nr);
      for (int r = nr - 1; r >= 1; r--) s = byte_round(s, 1, 1) ^ round_key(1, r);
      s = byte_round(s, 1, 0) ^ round_key(1, 0);
    end
    return s;
  endfunction

  logic [127:0] want;
  logic [2:0]   reg_idx;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] = 0;
      ksize_q = KeySize128;
      fail_count = 0;
      results_seen = 0;
      cipher_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[5:3];
        if (reg_idx <= RegKeySize) begin
          if (reg_idx == RegKeySize)
            ksize_q = pwdata[1:0] == 2'd3 ? KeySize256 : key_size_e'(pwdata[1:0]);
          else key_q[reg_idx] = pwdata;
          expand_schedule();
        end
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (cipher_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word %h_%h", result_hi_o, result_lo_o);
        end else begin
          want = cipher_q.pop_front();
          if (want[127:64] !== result_hi_o || want[63:0] !== result_lo_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %h_%h got %h_%h", want[127:64], want[63:0],
                       result_hi_o, result_lo_o);
          end
        end
      end
      if (in_valid_i && in_ready_o)
        cipher_q.push_back(aes_block(func_i, {block_hi_i, block_lo_i}));
    end
    pending = cipher_q.size();
  end

endmodule

// ----- test/aes_block_cipher_tb.sv -----
// Testbench top for aes_block_cipher: clock, reset, APB key setup, bursty block
// stimulus and a stalling receiver. Checking lives in aes_block_cipher_chk.
`timescale 1ns / 100ps
module aes_block_cipher_tb;
  import aes_pkg::*;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o, func_i;
  logic [63:0] block_hi_i, block_lo_i;
  logic        out_valid_o, out_ready_i;
  logic [63:0] result_hi_o, result_lo_o;
  int          fail_count, pending, results_seen;
  int          cycle_cnt;
  int          blocks_sent;

  aes_block_cipher dut (.*);
  aes_block_cipher_chk chk (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("timeout with %0d words outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern, with long stretches of always-ready
  int stall_mode;
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 0;
    else case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(3) != 0);
      default: out_ready_i <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (pending != 0 || in_valid_i) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo);
    in_valid_i <= 1; func_i <= dec; block_hi_i <= hi; block_lo_i <= lo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    blocks_sent++;
  endtask

  task automatic send_burst(int n);
    int burst;
    int gap;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        if ($urandom_range(7) == 0)
          send_block(1'($urandom_range(1)),
                     {$urandom, $urandom} & {8{8'(1 << $urandom_range(7))}},
                     {$urandom, $urandom});
        else send_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
      end
      gap = $urandom_range(0, 6);
      if (gap != 0 && n > 0) begin
        in_valid_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 0;
  endtask

  task automatic load_key(key_size_e ks, logic [1:0] raw_size, bit use_raw);
    for (int i = 0; i < 4; i++) apb_write(RegKey0 + 3'(i), {$urandom, $urandom});
    apb_write(RegKeySize, use_raw ? 64'(raw_size) : 64'(ks));
    repeat (70) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 0; cycle_cnt = 0; blocks_sent = 0; stall_mode = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; func_i = 0; block_hi_i = 0; block_lo_i = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // FIPS-197 128 bit example key, then edge blocks both ways
    apb_write(RegKey0, 64'h0001020304050607);
    apb_write(RegKey1, 64'h08090a0b0c0d0e0f);
    apb_write(RegKey2, 64'h0);
    apb_write(RegKey3, 64'h0);
    apb_write(RegKeySize, 64'(KeySize128));
    repeat (70) @(negedge clk_i);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(0, '0, '0);
    send_block(1, '1, '1);
    send_block(0, '1, '0);
    send_block(1, '0, '1);
    in_valid_i <= 0;
    drain();
    // all-ones key at each size, plus size code 3 which acts as 256
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 4; i++) apb_write(RegKey0 + 3'(i), '1);
      apb_write(RegKeySize, 64'(s));
      repeat (70) @(negedge clk_i);
      send_block(0, '1, '1);
      send_block(1, '1, '1);
      send_block(0, '0, '0);
      in_valid_i <= 0;
      drain();
    end
    // partial update: one key register rewritten without resizing
    apb_write(RegKey1, 64'h0);
    repeat (70) @(negedge clk_i);
    send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(1, 64'h0123456789abcdef, 64'hfedcba9876543210);
    in_valid_i <= 0;
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      stall_mode = ph % 3;
      load_key(key_size_e'(ph % 3), 2'd3, ph == 11);
      send_burst(120);
      drain();
    end

    repeat (30) @(negedge clk_i);
    $display("sent %0d blocks, checked %0d results over 128/192/256 bit keys", blocks_sent,
             results_seen);
    $display("encrypt and decrypt mixed, bursty input with stalled output");
    if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
